// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SUS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sus assertion failed");

// Next-cycle implication, checked outside reset.
`define SUS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sus assertion failed");

`endif

// ===== rtl/sus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

    localparam int VALUE_W          = 32;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] held_count;
    } out_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                      capture;
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sus_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sus_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire                                     aclk,
    input  wire sus_pkg::cell_ctrl_t                ctrl,
    input  wire logic [CNT_W-1:0]                   count,
    input  wire logic                               prev_lt,
    input  wire logic signed [sus_pkg::VALUE_W-1:0] left_val,
    input  wire logic signed [sus_pkg::VALUE_W-1:0] right_val,
    output logic signed [sus_pkg::VALUE_W-1:0]      val,
    output logic                                    lt,
    output logic                                    eq
);

    logic signed [sus_pkg::VALUE_W-1:0] val_reg;
    logic signed [sus_pkg::VALUE_W-1:0] val_next;
    logic                               lt_reg;
    logic                               eq_reg;
    logic                               occupied;

    assign occupied = count > CNT_W'(IDX);

    // Cells at or after the insert point take the new value or their left
    // neighbor; on a remove they pull from the right neighbor.
    always_comb begin
        val_next = val_reg;
        if (ctrl.ins && !lt_reg) begin
            val_next = prev_lt ? ctrl.key : left_val;
        end else if (ctrl.rem && !lt_reg) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (ctrl.capture) begin
            lt_reg <= occupied && (val_reg < ctrl.key);
            eq_reg <= occupied && (val_reg == ctrl.key);
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_unique_set_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Beat
// s_        in         s_valid / s_ready   sus_pkg::in_t  (func, value)
// m_        out        m_valid / m_ready   sus_pkg::out_t (status, held_count)
//
// Each request goes through accept, a compare in every cell of the
// row, and the shift that applies the insert or remove.
// The shift cycle waits while the previous result beat is still not taken.
// Synchronous active-low reset empties the set; stored values are not cleared.

module sorted_unique_set_engine #(
    parameter int CAPACITY = sus_pkg::DEFAULT_CAPACITY
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire sus_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output sus_pkg::out_t       m_data
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                             state_reg;
    logic                               func_reg;
    logic signed [sus_pkg::VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic                               m_valid_reg;
    sus_pkg::out_t                      m_data_reg;

    sus_pkg::cell_ctrl_t                ctrl;
    logic signed [sus_pkg::VALUE_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]                lt_vec;
    logic [CAPACITY-1:0]                eq_vec;
    logic                               hit;
    logic                               full;
    logic                               out_free;
    logic                               do_upd;
    logic [2:0]                         status_next;
    logic [CNT_W-1:0]                   count_next;

    assign out_free = !m_valid_reg || m_ready;
    assign do_upd   = (state_reg == S_UPD) && out_free;
    assign hit      = |eq_vec;
    assign full     = count_reg == CNT_W'(CAPACITY);

    always_comb begin
        ctrl.capture = state_reg == S_CMP;
        ctrl.key     = key_reg;
        ctrl.ins     = do_upd && (func_reg == sus_pkg::FUNC_INSERT) && !hit && !full;
        ctrl.rem     = do_upd && (func_reg == sus_pkg::FUNC_REMOVE) && hit;
    end

    always_comb begin
        count_next = count_reg;
        if (func_reg == sus_pkg::FUNC_INSERT) begin
            if (hit) begin
                status_next = sus_pkg::ST_PRESENT;
            end else if (full) begin
                status_next = sus_pkg::ST_FULL;
            end else begin
                status_next = sus_pkg::ST_INSERTED;
                count_next  = count_reg + CNT_W'(1);
            end
        end else begin
            if (hit) begin
                status_next = sus_pkg::ST_REMOVED;
                count_next  = count_reg - CNT_W'(1);
            end else begin
                status_next = sus_pkg::ST_ABSENT;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                               prev_lt;
            logic signed [sus_pkg::VALUE_W-1:0] left_val;
            logic signed [sus_pkg::VALUE_W-1:0] right_val;

            // Cell 0 sees a virtual smaller neighbor, so it takes the key itself.
            if (gi == 0) begin : g_first
                assign prev_lt  = 1'b1;
                assign left_val = key_reg;
            end else begin : g_mid
                assign prev_lt  = lt_vec[gi-1];
                assign left_val = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_val = cell_val[gi];
            end else begin : g_inner
                assign right_val = cell_val[gi+1];
            end

            sus_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .prev_lt   (prev_lt),
                .left_val  (left_val),
                .right_val (right_val),
                .val       (cell_val[gi]),
                .lt        (lt_vec[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_upd) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_data.func;
                        key_reg   <= s_data.value;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        count_reg             <= count_next;
                        m_data_reg.status     <= status_next;
                        m_data_reg.held_count <= 5'(count_next);
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SUS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SUS_ASSERT_NOW(a_single_match, aclk, aresetn, state_reg == S_UPD, $countones(eq_vec) <= 1)
    `SUS_ASSERT_NEXT(a_insert_grows, aclk, aresetn, ctrl.ins, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire
